// File: rtl/core/msr_pkg.sv
// Shared types and constants for the MIDI sysex chunk reassembler.
`timescale 1ns / 1ps

package msr_pkg;

    // MIDI byte codes
    localparam logic [7:0] BYTE_SOX    = 8'hF0;
    localparam logic [7:0] BYTE_EOX    = 8'hF7;
    localparam logic [7:0] BYTE_RT_MIN = 8'hF8;

    // Sysex length counter
    localparam int unsigned LENGTH_BITS = 16;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // Command queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    // Back-end sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_PRE  = 3'd1,
        PH_MAIN = 3'd2,
        PH_DATA = 3'd3,
        PH_POST = 3'd4
    } t_phase;

    // Decoded work for one input beat
    typedef struct packed {
        logic        err;        // read error result
        logic        pre_end;    // truncating end of the open sysex first
        logic        short_msg;  // short message result
        logic        open;       // chunk opens a new sysex
        logic        chunk;      // emit chunk bytes
        logic [1:0]  last_idx;   // index of last chunk byte emitted
        logic        end_after;  // chunk closes the sysex
        logic        end_trunc;  // closing byte was not EOX
        logic [31:0] word;
        logic [31:0] stamp;
    } t_cmd;

endpackage

// File: rtl/core/msr_fifo.sv
// Short command queue between the decode front and the result back end.
`timescale 1ns / 1ps

module msr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  msr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output msr_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    msr_pkg::t_cmd                r_mem [msr_pkg::FIFO_DEPTH];
    logic [msr_pkg::FIFO_AW-1:0]  r_wr_ptr;
    logic [msr_pkg::FIFO_AW-1:0]  r_rd_ptr;
    logic [msr_pkg::FIFO_AW:0]    r_used;
    logic [msr_pkg::FIFO_AW-1:0]  n_wr_ptr;
    logic [msr_pkg::FIFO_AW-1:0]  n_rd_ptr;
    logic [msr_pkg::FIFO_AW:0]    n_used;

    assign o_full  = (r_used == (msr_pkg::FIFO_AW+1)'(msr_pkg::FIFO_DEPTH));
    assign o_empty = (r_used == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_used   = r_used;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == msr_pkg::FIFO_AW'(msr_pkg::FIFO_DEPTH - 1)) ?
                       '0 : r_wr_ptr + msr_pkg::FIFO_AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == msr_pkg::FIFO_AW'(msr_pkg::FIFO_DEPTH - 1)) ?
                       '0 : r_rd_ptr + msr_pkg::FIFO_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_used = r_used + (msr_pkg::FIFO_AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_used = r_used - (msr_pkg::FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_used   <= n_used;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/core/msr_front.sv
// Decode front: accepts event beats, tracks sysex state, builds commands.
`timescale 1ns / 1ps

module msr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [31:0]   i_word,
    input  logic [31:0]   i_stamp,
    input  logic          i_error,
    input  logic          i_full,
    output logic          o_push,
    output msr_pkg::t_cmd o_cmd
);

    logic       r_in_sysex;
    logic       n_in_sysex;
    logic [7:0] w_s;
    logic [3:0] w_term;
    logic       w_close;
    logic       w_close_trunc;
    logic [1:0] w_last_idx;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_s     = i_word[7:0];

    // find the first byte of the chunk that ends the sysex
    always_comb begin
        logic [7:0] b;
        w_close       = 1'b0;
        w_close_trunc = 1'b0;
        w_last_idx    = 2'd3;
        w_term        = '0;
        for (int i = 0; i < 4; i++) begin
            b = i_word[8*i +: 8];
            w_term[i] = (b == msr_pkg::BYTE_EOX) || (b[7] && (b != msr_pkg::BYTE_SOX));
            if (w_term[i] && !w_close) begin
                w_close       = 1'b1;
                w_close_trunc = (b != msr_pkg::BYTE_EOX);
                w_last_idx    = 2'(i);
            end
        end
    end

    // classify the beat
    always_comb begin
        o_cmd            = '0;
        o_cmd.word       = i_word;
        o_cmd.stamp      = i_stamp;
        o_cmd.last_idx   = w_last_idx;
        o_cmd.end_after  = w_close;
        o_cmd.end_trunc  = w_close_trunc;
        n_in_sysex       = r_in_sysex;
        if (i_error) begin
            o_cmd.err  = 1'b1;
            n_in_sysex = 1'b0;
        end else if (r_in_sysex) begin
            if (w_s >= msr_pkg::BYTE_RT_MIN) begin
                // real-time byte passes through, sysex stays open
                o_cmd.short_msg = 1'b1;
                o_cmd.word      = {24'd0, w_s};
            end else if (w_s[7] && (w_s != msr_pkg::BYTE_EOX)) begin
                // status byte cuts the sysex, then starts a new event
                o_cmd.pre_end = 1'b1;
                if (w_s == msr_pkg::BYTE_SOX) begin
                    o_cmd.open  = 1'b1;
                    o_cmd.chunk = 1'b1;
                    n_in_sysex  = !w_close;
                end else begin
                    o_cmd.short_msg = 1'b1;
                    o_cmd.word      = {8'd0, i_word[23:0]};
                    n_in_sysex      = 1'b0;
                end
            end else begin
                o_cmd.chunk = 1'b1;
                n_in_sysex  = !w_close;
            end
        end else begin
            if (w_s == msr_pkg::BYTE_SOX) begin
                o_cmd.open  = 1'b1;
                o_cmd.chunk = 1'b1;
                n_in_sysex  = !w_close;
            end else begin
                o_cmd.short_msg = 1'b1;
                o_cmd.word      = {8'd0, i_word[23:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sysex <= 1'b0;
        end else if (o_push) begin
            r_in_sysex <= n_in_sysex;
        end
    end

endmodule

// File: rtl/core/msr_back.sv
// Result back end: walks each command one result per cycle, while the output is not stalled, into an output register.
`timescale 1ns / 1ps

module msr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  msr_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [79:0]   o_data,
    output logic [1:0]    o_kind,
    output logic          o_last
);

    msr_pkg::t_phase                 r_phase;
    msr_pkg::t_phase                 n_phase;
    msr_pkg::t_phase                 w_after;
    msr_pkg::t_phase                 w_start;
    msr_pkg::t_cmd                   r_cmd;
    logic [1:0]                      r_idx;
    logic [1:0]                      n_idx;
    logic [msr_pkg::LENGTH_BITS-1:0] r_count;
    logic [msr_pkg::LENGTH_BITS-1:0] n_count;
    logic                            r_ovf;
    logic                            n_ovf;
    logic [31:0]                     r_start_stamp;
    logic [31:0]                     n_start_stamp;
    logic                            w_busy;
    logic                            w_emit;
    logic                            w_done;
    logic                            w_load;

    // result fields
    msr_pkg::t_kind                  w_kind;
    logic [7:0]                      w_status;
    logic [7:0]                      w_d1;
    logic [7:0]                      w_d2;
    logic [31:0]                     w_stamp;
    logic [15:0]                     w_len;
    logic                            w_trunc;
    logic                            w_rovf;

    // output register
    logic                            r_m_valid;
    msr_pkg::t_kind                  r_m_kind;
    logic [79:0]                     r_m_data;
    logic                            r_m_last;

    assign w_busy = (r_phase != msr_pkg::PH_IDLE);
    assign w_emit = w_busy && (!r_m_valid || i_ready);
    assign w_load = !i_empty && (!w_busy || (w_emit && w_done));
    assign o_pop  = w_load;

    assign o_valid = r_m_valid;
    assign o_kind  = r_m_kind;
    assign o_data  = r_m_data;
    assign o_last  = r_m_last;

    // entry phase of the queue head
    always_comb begin
        if (i_cmd.pre_end) begin
            w_start = msr_pkg::PH_PRE;
        end else if (i_cmd.chunk) begin
            w_start = msr_pkg::PH_DATA;
        end else begin
            w_start = msr_pkg::PH_MAIN;
        end
    end

    // result of the current phase and the phase that follows
    always_comb begin
        w_kind        = msr_pkg::KIND_SHORT;
        w_status      = '0;
        w_d1          = '0;
        w_d2          = '0;
        w_stamp       = r_cmd.stamp;
        w_len         = '0;
        w_trunc       = 1'b0;
        w_rovf        = 1'b0;
        w_done        = 1'b1;
        w_after       = msr_pkg::PH_IDLE;
        n_count       = r_count;
        n_ovf         = r_ovf;
        n_start_stamp = r_start_stamp;
        case (r_phase)
            msr_pkg::PH_PRE: begin
                w_kind  = msr_pkg::KIND_END;
                w_stamp = r_start_stamp;
                w_len   = 16'(r_count);
                w_trunc = 1'b1;
                w_rovf  = r_ovf;
                w_done  = 1'b0;
                w_after = r_cmd.short_msg ? msr_pkg::PH_MAIN : msr_pkg::PH_DATA;
                n_count = '0;
                n_ovf   = 1'b0;
            end
            msr_pkg::PH_MAIN: begin
                if (r_cmd.err) begin
                    w_kind  = msr_pkg::KIND_ERROR;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end else begin
                    w_kind   = msr_pkg::KIND_SHORT;
                    w_status = r_cmd.word[7:0];
                    w_d1     = r_cmd.word[15:8];
                    w_d2     = r_cmd.word[23:16];
                end
            end
            msr_pkg::PH_DATA: begin
                w_kind   = msr_pkg::KIND_DATA;
                w_status = r_cmd.word[{r_idx, 3'b000} +: 8];
                // saturating length count
                if (r_count == msr_pkg::LEN_MAX) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + msr_pkg::LENGTH_BITS'(1);
                end
                if (r_cmd.open && (r_idx == 2'd0)) begin
                    n_start_stamp = r_cmd.stamp;
                end
                if (r_idx == r_cmd.last_idx) begin
                    w_done  = !r_cmd.end_after;
                    w_after = r_cmd.end_after ? msr_pkg::PH_POST : msr_pkg::PH_IDLE;
                end else begin
                    w_done  = 1'b0;
                    w_after = msr_pkg::PH_DATA;
                end
            end
            msr_pkg::PH_POST: begin
                w_kind  = msr_pkg::KIND_END;
                w_stamp = r_start_stamp;
                w_len   = 16'(r_count);
                w_trunc = r_cmd.end_trunc;
                w_rovf  = r_ovf;
                n_count = '0;
                n_ovf   = 1'b0;
            end
            default: begin
                w_done = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (w_load) begin
            n_phase = w_start;
            n_idx   = 2'd0;
        end else if (w_emit) begin
            n_phase = w_done ? msr_pkg::PH_IDLE : w_after;
            if ((r_phase == msr_pkg::PH_DATA) && (w_after == msr_pkg::PH_DATA)) begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= msr_pkg::PH_IDLE;
            r_idx         <= 2'd0;
            r_count       <= '0;
            r_ovf         <= 1'b0;
            r_start_stamp <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (w_emit) begin
                r_count       <= n_count;
                r_ovf         <= n_ovf;
                r_start_stamp <= n_start_stamp;
                r_m_valid     <= 1'b1;
            end else if (i_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // command and output payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_cmd;
        end
        if (w_emit) begin
            r_m_kind <= w_kind;
            r_m_last <= w_done;
            r_m_data <= {6'd0, w_rovf, w_trunc, w_len, w_stamp, w_d2, w_d1, w_status};
        end
    end

endmodule

// File: rtl/core/midi_sysex_chunk_reassembler.sv
// Path: an accepted beat is queued, loaded into the result sequencer, then each result is registered.
// Throughput: one result beat per cycle while the output is not stalled; an event causes
//   1 to 6 results, all emitted by the single result sequencer; a 4-entry command queue
//   lets input beats be taken while earlier events are still being emitted.
// Reset: i_rst_n synchronous, active low; clears sysex tracking, queue and output valid.
`timescale 1ns / 1ps

module midi_sysex_chunk_reassembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // message_word[31:0], stamp_in[63:32]
    input  logic [0:0]  s_axis_tuser,   // read_error[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // status_byte[7:0], data_one[15:8], data_two[23:16],
                                        // stamp[55:24], sysex_length[71:56], truncated[72],
                                        // overflowed[73], zero[79:74]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast    // last_of_run
);

    msr_pkg::t_cmd w_push_cmd;
    msr_pkg::t_cmd w_head_cmd;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;

    // decode and classify
    msr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (s_axis_tdata[31:0]),
        .i_stamp (s_axis_tdata[63:32]),
        .i_error (s_axis_tuser[0]),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // command queue
    msr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // result sequencing
    msr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_head_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_kind  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

// File: dv/tb.sv
// Self-checking testbench for the MIDI sysex chunk reassembler stream block.
`timescale 1ns / 1ps

module tb;
    import msr_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 110;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned MAX_REPORTS   = 100;
    localparam longint     TIMEOUT_NS    = 5_000_000;

    // One result beat as seen on the master side
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  status_byte;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [31:0] stamp;
        logic [15:0] sysex_length;
        logic        truncated;
        logic        overflowed;
        logic        last_of_run;
    } midi_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // message_word[31:0], stamp_in[63:32]
    logic [0:0]  s_axis_tuser = '0;   // read_error[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;        // status_byte, data_one, data_two, stamp, sysex_length,
                                      // truncated, overflowed, zero pad
    logic [1:0]  m_axis_tuser;        // kind[1:0]
    logic        m_axis_tlast;        // last_of_run

    // Sysex tracking mirror
    logic                   sysex_open;
    logic [31:0]            sysex_start;
    logic [LENGTH_BITS-1:0] sysex_bytes;
    logic                   sysex_saturated;

    midi_result_t predicted_results[$];
    int failures = 0;
    int items_sent = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold_request = 0;
    int sink_stall_left = 0;
    int idle_levels[3] = '{0, 25, 60};

    midi_sysex_chunk_reassembler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[midi_sysex_chunk_reassembler] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Event decoder mirror
    // ---------------------------------------------------------------
    function automatic void push_result(input t_kind kind, input logic [7:0] sb,
                                        input logic [7:0] d1, input logic [7:0] d2,
                                        input logic [31:0] st, input logic [15:0] len,
                                        input logic tr, input logic ov);
        midi_result_t r;
        r.kind         = kind;
        r.status_byte  = sb;
        r.data_one     = d1;
        r.data_two     = d2;
        r.stamp        = st;
        r.sysex_length = len;
        r.truncated    = tr;
        r.overflowed   = ov;
        r.last_of_run  = 1'b0;
        predicted_results.push_back(r);
    endfunction

    function automatic void end_sysex(input logic trunc);
        push_result(KIND_END, 8'h00, 8'h00, 8'h00, sysex_start, sysex_bytes[15:0],
                    trunc, sysex_saturated);
        sysex_open      = 1'b0;
        sysex_bytes     = '0;
        sysex_saturated = 1'b0;
    endfunction

    // Chunk bytes go out low byte first until EOX or a stray status byte
    function automatic void absorb_chunk(input logic [31:0] word, input logic [31:0] stamp);
        logic [7:0] code;
        for (int i = 0; i < 4; i++) begin
            code = word[8*i +: 8];
            push_result(KIND_DATA, code, 8'h00, 8'h00, stamp, 16'h0000, 1'b0, 1'b0);
            if (sysex_bytes == LEN_MAX)
                sysex_saturated = 1'b1;
            else
                sysex_bytes = sysex_bytes + 1'b1;
            if (code == BYTE_EOX) begin
                end_sysex(1'b0);
                return;
            end
            if (code[7] && code != BYTE_SOX) begin
                end_sysex(1'b1);
                return;
            end
        end
    endfunction

    function automatic void decode_event(input logic [31:0] word, input logic [31:0] stamp,
                                         input logic err);
        logic [7:0]   lead;
        logic         handled;
        midi_result_t tail;
        lead    = word[7:0];
        handled = 1'b0;
        if (err) begin
            sysex_open      = 1'b0;
            sysex_bytes     = '0;
            sysex_saturated = 1'b0;
            push_result(KIND_ERROR, 8'h00, 8'h00, 8'h00, stamp, 16'h0000, 1'b0, 1'b0);
        end else begin
            if (sysex_open) begin
                handled = 1'b1;
                if (lead >= BYTE_RT_MIN) begin
                    push_result(KIND_SHORT, lead, 8'h00, 8'h00, stamp, 16'h0000, 1'b0, 1'b0);
                end else if (lead[7] && lead != BYTE_EOX) begin
                    // truncating end, then the status word starts over as a new event
                    end_sysex(1'b1);
                    handled = 1'b0;
                end else begin
                    absorb_chunk(word, stamp);
                end
            end
            if (!handled) begin
                if (lead == BYTE_SOX) begin
                    sysex_open      = 1'b1;
                    sysex_start     = stamp;
                    sysex_bytes     = '0;
                    sysex_saturated = 1'b0;
                    absorb_chunk(word, stamp);
                end else begin
                    push_result(KIND_SHORT, lead, word[15:8], word[23:16], stamp, 16'h0000,
                                1'b0, 1'b0);
                end
            end
        end
        tail = predicted_results.pop_back();
        tail.last_of_run = 1'b1;
        predicted_results.push_back(tail);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int pick_idle(input int pct);
        if ($urandom_range(99, 0) >= pct)
            return 0;
        if ($urandom_range(7, 0) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [31:0] random_data_chunk();
        return $urandom & 32'h7F7F_7F7F;
    endfunction

    function automatic logic [31:0] open_chunk();
        logic [31:0] w;
        w = random_data_chunk();
        return {w[31:8], BYTE_SOX};
    endfunction

    // Valid stays up across back-to-back beats; it only drops for a gap
    task automatic send_event(input logic [31:0] word, input logic [31:0] stamp,
                              input logic err);
        int gap;
        gap = pick_idle(src_idle_pct);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, word};
        s_axis_tuser  <= err;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_event(word, stamp, err);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (predicted_results.size() != 0);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls plus an on-demand long hold
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (sink_hold_request > 0) begin
            sink_stall_left   = sink_hold_request;
            sink_hold_request = 0;
        end else if (sink_stall_left == 0) begin
            sink_stall_left = pick_idle(sink_stall_pct);
        end
        if (sink_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            sink_stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= MAX_REPORTS)
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        midi_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $error("unexpected result beat: kind %0d, byte 0x%0h",
                           m_axis_tuser, m_axis_tdata[7:0]);
            end else begin
                want = predicted_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("status_byte", 32'(want.status_byte), 32'(m_axis_tdata[7:0]));
                check_field("data_one", 32'(want.data_one), 32'(m_axis_tdata[15:8]));
                check_field("data_two", 32'(want.data_two), 32'(m_axis_tdata[23:16]));
                check_field("stamp", want.stamp, m_axis_tdata[55:24]);
                check_field("sysex_length", 32'(want.sysex_length),
                            32'(m_axis_tdata[71:56]));
                check_field("truncated", 32'(want.truncated), 32'(m_axis_tdata[72]));
                check_field("overflowed", 32'(want.overflowed), 32'(m_axis_tdata[73]));
                check_field("last_of_run", 32'(want.last_of_run), 32'(m_axis_tlast));
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_short_messages();
        src_idle_pct   = 30;
        sink_stall_pct = 30;
        send_event({8'h00, 8'h00, 8'h00, 8'h80}, 32'h0000_0000, 1'b0);
        send_event({8'hFF, 8'h7F, 8'h00, 8'hEF}, 32'hFFFF_FFFF, 1'b0);
        send_event({8'h12, 8'h34, 8'h56, 8'h00}, 32'h5555_5555, 1'b0);
        // EOX with no open sysex is just a short message
        send_event({8'hAB, 8'hCD, 8'hEF, BYTE_EOX}, 32'hAAAA_AAAA, 1'b0);
        send_event(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send_event({24'h13_579B, BYTE_RT_MIN}, $urandom, 1'b0);
        send_event({24'h24_68AC, 8'hF1}, $urandom, 1'b0);
        send_event(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_sysex_framing();
        src_idle_pct   = 20;
        sink_stall_pct = 20;
        // shortest complete sysex
        send_event({16'h0000, BYTE_EOX, BYTE_SOX}, 32'h0000_1000, 1'b0);
        // real-time byte passes through, sysex stays open
        send_event({24'h7F_0102, BYTE_SOX}, 32'h0000_2000, 1'b0);
        send_event({24'h12_3456, 8'hFE}, $urandom, 1'b0);
        send_event({BYTE_EOX, 24'h00_0000}, $urandom, 1'b0);
        // inner SOX is data; inner real-time byte truncates and drops the rest
        send_event({8'h10, BYTE_SOX, 8'h20, BYTE_SOX}, $urandom, 1'b0);
        send_event({8'h00, BYTE_RT_MIN, 16'h1020}, $urandom, 1'b0);
        // SOX as lead byte inside a sysex: truncating end plus a full new sysex
        send_event({24'h00_0000, BYTE_SOX}, $urandom, 1'b0);
        send_event({BYTE_EOX, 16'h1122, BYTE_SOX}, $urandom, 1'b0);
        // channel status as lead byte: truncating end, then a short message
        send_event({24'h03_0201, BYTE_SOX}, $urandom, 1'b0);
        send_event({24'h00_4050, 8'h90}, $urandom, 1'b0);
        // EOX as lead byte of a later chunk
        send_event({24'h03_0201, BYTE_SOX}, $urandom, 1'b0);
        send_event(32'h0000_0077, $urandom, 1'b0);
        send_event({24'h00_0000, BYTE_EOX}, $urandom, 1'b0);
        // status byte inside the opening chunk
        send_event({8'h01, 8'h90, 8'h05, BYTE_SOX}, $urandom, 1'b0);
        // read error drops the open sysex without an end beat
        send_event({24'h0A_0B0C, BYTE_SOX}, $urandom, 1'b0);
        send_event({24'h12_3456, BYTE_EOX}, $urandom, 1'b1);
        send_event(32'h0000_0055, $urandom, 1'b0);
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // receiver holds off while a long sysex is pushed in back to back
        sink_hold_request = 300;
        send_event(open_chunk(), $urandom, 1'b0);
        repeat (12) send_event(random_data_chunk(), $urandom, 1'b0);
        send_event({24'h00_0000, BYTE_EOX}, $urandom, 1'b0);
        // sender pauses until everything is out, then resumes
        drain_results();
        src_idle_pct   = 50;
        sink_stall_pct = 50;
        repeat (6) send_event($urandom, $urandom, 1'b0);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int          start;
        int          pick;
        int          pos;
        logic [31:0] word;
        logic [7:0]  code;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(5, 0) == 0) begin
                src_idle_pct   = idle_levels[$urandom_range(2, 0)];
                sink_stall_pct = idle_levels[$urandom_range(2, 0)];
            end
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                // well-formed sysex, real-time beats mixed in
                send_event(open_chunk(), $urandom, 1'b0);
                repeat ($urandom_range(4, 0)) begin
                    if ($urandom_range(5, 0) == 0) begin
                        word = $urandom;
                        word[7:0] = 8'($urandom_range(255, 248));
                        send_event(word, $urandom, 1'b0);
                    end
                    send_event(random_data_chunk(), $urandom, 1'b0);
                end
                word = random_data_chunk();
                pos  = $urandom_range(3, 0);
                word[8*pos +: 8] = BYTE_EOX;
                for (int k = 0; k < 4; k++)
                    if (k > pos)
                        word[8*k +: 8] = 8'($urandom_range(255, 0));
                send_event(word, $urandom, 1'b0);
            end else if (pick < 75) begin
                // sysex followed by a chunk holding a non-EOX status byte at a random position
                send_event(open_chunk(), $urandom, 1'b0);
                repeat ($urandom_range(2, 0)) send_event(random_data_chunk(), $urandom, 1'b0);
                word = random_data_chunk();
                pos  = $urandom_range(3, 0);
                code = 8'($urandom_range(255, 128));
                if (code == BYTE_EOX)
                    code = 8'hF6;
                word[8*pos +: 8] = code;
                send_event(word, $urandom, 1'b0);
            end else if (pick < 85) begin
                // read error in the middle of a sysex
                send_event(open_chunk(), $urandom, 1'b0);
                if ($urandom_range(1, 0) == 1)
                    send_event(random_data_chunk(), $urandom, 1'b0);
                send_event($urandom, $urandom, 1'b1);
            end else begin
                send_event($urandom, $urandom, $urandom_range(9, 0) == 0);
            end
            if ($urandom_range(9, 0) == 0)
                drain_results();
        end
    endtask

    initial begin
        sysex_open      = 1'b0;
        sysex_start     = '0;
        sysex_bytes     = '0;
        sysex_saturated = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_messages();
        test_sysex_framing();
        test_backpressure();
        test_random_traffic();

        drain_results();
        sink_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("[midi_sysex_chunk_reassembler] OK");
        else
            $display("[midi_sysex_chunk_reassembler] ERROR");
        $finish;
    end

endmodule
